### sv/aip_pkg.sv
package aip_pkg;

	localparam int VAL_W    = 64;
	localparam int OFF_W    = 11;
	localparam int BASE_W   = 6;
	localparam int DIG_W    = 6;
	localparam int CHAR_W   = 8;
	localparam int PROD_W   = VAL_W + BASE_W;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	localparam logic [BASE_W-1:0] MAX_BASE = 6'd36;
	localparam logic [BASE_W-1:0] DEF_BASE = 6'd10;
	localparam logic [BASE_W-1:0] OCT_BASE = 6'd8;
	localparam logic [BASE_W-1:0] HEX_BASE = 6'd16;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5a;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7a;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] UPPER_OFS = 8'd55;
	localparam logic [CHAR_W-1:0] LOWER_OFS = 8'd87;

	localparam logic REG_BASE   = 1'b0;
	localparam logic REG_SIGNED = 1'b1;

	typedef struct packed {
		logic              new_str;
		logic              space;
		logic              plus;
		logic              minus;
		logic              xchar;
		logic              dig_ok;
		logic [DIG_W-1:0]  dig;
	} entry_t;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic              sgn;
	} cfg_t;

endpackage

### sv/ascii_integer_parser.sv
// channel  | handshake            | payload
// input    | push / full          | char_in, new_string
// result   | empty / pop          | value, stop_offset, overflow
// config   | psel penable pwrite  | paddr, pwdata, prdata (pready tied high)
//
// one word per cycle sustained while no result waits unpopped; the back stage's 64 x 6 multiply-add sets the pace
// a word waits in the queue, and a result is registered when the back stage takes its final word
// reset: base 10, signed mode on, parser ignores words until one with new_string
// full rises once QUEUE_DEPTH words wait behind a result that is not popped
module ascii_integer_parser import aip_pkg::*; #(
	parameter int MAX_LEN     = 1024,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [CHAR_W-1:0] char_in,
	input  logic              new_string,
	output logic              empty,
	input  logic              pop,
	output logic [VAL_W-1:0]  value,
	output logic [OFF_W-1:0]  stop_offset,
	output logic              overflow,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t   cfg_q;
	entry_t front_entry;
	entry_t q_entry;
	logic   q_valid;
	logic   q_take;
	logic   out_valid;
	logic   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign empty  = !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base <= DEF_BASE;
			cfg_q.sgn  <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_BASE:   cfg_q.base <= pwdata[BASE_W-1:0];
				REG_SIGNED: cfg_q.sgn  <= pwdata[0];
				default:    cfg_q      <= cfg_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (paddr[2])
				REG_BASE:   prdata = APB_DW'(cfg_q.base);
				REG_SIGNED: prdata = APB_DW'(cfg_q.sgn);
				default:    prdata = '0;
			endcase
		end
	end

	aip_front u_front (
		.char_in    (char_in),
		.new_string (new_string),
		.entry      (front_entry)
	);

	aip_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (push),
		.wr_data  (front_entry),
		.full     (full),
		.rd       (q_take),
		.rd_valid (q_valid),
		.rd_data  (q_entry)
	);

	aip_back #(
		.MAX_LEN (MAX_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (q_valid),
		.in_entry   (q_entry),
		.in_take    (q_take),
		.out_valid  (out_valid),
		.out_pop    (pop),
		.out_value  (value),
		.out_offset (stop_offset),
		.out_ovf    (overflow)
	);

	a_back_drains: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && (empty || pop) |-> q_take)
		else $error("back stage stalled with room for a result");

	a_take_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid)
		else $error("back stage took from an empty queue");

	a_result_from_word: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && ($past(empty) || $past(pop)) |-> $past(q_take))
		else $error("result appeared without a word consumed");

endmodule

### sv/aip_front.sv
module aip_front import aip_pkg::*; (
	input  logic [CHAR_W-1:0] char_in,
	input  logic              new_string,
	output entry_t            entry
);

	logic [CHAR_W-1:0] dig_full;
	logic              is_num;
	logic              is_upper;
	logic              is_lower;

	always_comb begin
		is_num   = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
		is_upper = (char_in >= CH_UA) && (char_in <= CH_UZ);
		is_lower = (char_in >= CH_LA) && (char_in <= CH_LZ);
		priority if (is_num) begin
			dig_full = char_in - CH_ZERO;
		end else if (is_upper) begin
			dig_full = char_in - UPPER_OFS;
		end else if (is_lower) begin
			dig_full = char_in - LOWER_OFS;
		end else begin
			dig_full = '0;
		end
		entry.new_str = new_string;
		entry.space   = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
		entry.plus    = (char_in == CH_PLUS);
		entry.minus   = (char_in == CH_MINUS);
		entry.xchar   = (char_in == CH_LX) || (char_in == CH_UX);
		entry.dig_ok  = is_num || is_upper || is_lower;
		entry.dig     = dig_full[DIG_W-1:0];
	end

endmodule

### sv/aip_queue.sv
module aip_queue import aip_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  entry_t wr_data,
	output logic   full,
	input  logic   rd,
	output logic   rd_valid,
	output entry_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign do_wr    = wr && !full;
	assign do_rd    = rd && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/aip_back.sv
module aip_back import aip_pkg::*; #(
	parameter int MAX_LEN = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	input  entry_t           in_entry,
	output logic             in_take,
	output logic             out_valid,
	input  logic             out_pop,
	output logic [VAL_W-1:0] out_value,
	output logic [OFF_W-1:0] out_offset,
	output logic             out_ovf
);

	localparam int POS_W = $clog2(MAX_LEN + 1);

	typedef enum logic [5:0] {
		PH_IDLE    = 6'b000001,
		PH_WS1     = 6'b000010,
		PH_WS2     = 6'b000100,
		PH_PREFIX0 = 6'b001000,
		PH_AFTERX  = 6'b010000,
		PH_DIGITS  = 6'b100000
	} phase_t;

	phase_t            ph_q, ph_c, ph_n;
	logic [VAL_W-1:0]  acc_q, acc_c, acc_n;
	logic [BASE_W-1:0] eb_q, eb_c, eb_n;
	logic              neg_q, neg_c, neg_n;
	logic [POS_W-1:0]  pos_q, pos_c, pos_n, pos_inc;
	logic              wr_q, wr_c, wr_n;

	logic [BASE_W-1:0] cfg_b, start_eb, run_eb, mul_b;
	logic [PROD_W-1:0] prod;
	logic              dig_in, start_pfx, do_start, do_take, do_finish;
	logic              emit;
	logic [VAL_W-1:0]  emit_val;
	logic [POS_W-1:0]  emit_off;
	logic              emit_ovf;

	logic              ov_q;
	logic [VAL_W-1:0]  val_q;
	logic [POS_W-1:0]  off_q;
	logic              ovf_q;

	assign in_take    = in_valid && (!ov_q || out_pop);
	assign out_valid  = ov_q;
	assign out_value  = val_q;
	assign out_offset = OFF_W'(off_q);
	assign out_ovf    = ovf_q;

	always_comb begin
		ph_c  = in_entry.new_str ? PH_WS1 : ph_q;
		acc_c = in_entry.new_str ? '0 : acc_q;
		eb_c  = in_entry.new_str ? '0 : eb_q;
		neg_c = in_entry.new_str ? 1'b0 : neg_q;
		pos_c = in_entry.new_str ? '0 : pos_q;
		wr_c  = in_entry.new_str ? 1'b0 : wr_q;

		cfg_b     = (cfg.base > MAX_BASE) ? MAX_BASE : cfg.base;
		start_eb  = (cfg_b == '0) ? DEF_BASE : cfg_b;
		run_eb    = (eb_c == '0) ? DEF_BASE : eb_c;
		mul_b     = (ph_c == PH_WS1 || ph_c == PH_WS2) ? start_eb : run_eb;
		start_pfx = ((cfg_b == '0) || (cfg_b == HEX_BASE)) && in_entry.dig_ok
			&& (in_entry.dig == '0);
		prod      = PROD_W'(acc_c) * PROD_W'(mul_b) + PROD_W'(in_entry.dig);
		dig_in    = in_entry.dig_ok && (in_entry.dig < mul_b);
		pos_inc   = (pos_c < POS_W'(MAX_LEN)) ? pos_c + 1'b1 : pos_c;

		ph_n      = ph_c;
		acc_n     = acc_c;
		eb_n      = eb_c;
		neg_n     = neg_c;
		pos_n     = pos_c;
		wr_n      = wr_c;
		do_start  = 1'b0;
		do_take   = 1'b0;
		do_finish = 1'b0;
		emit      = 1'b0;
		emit_val  = '0;
		emit_off  = '0;
		emit_ovf  = 1'b0;

		unique case (ph_c)
			PH_WS1: begin
				priority if (in_entry.space) begin
					pos_n = pos_inc;
				end else if (cfg.sgn && (in_entry.plus || in_entry.minus)) begin
					neg_n = in_entry.minus;
					ph_n  = PH_WS2;
					pos_n = pos_inc;
				end else begin
					do_start = 1'b1;
				end
			end
			PH_WS2: begin
				if (in_entry.space) begin
					pos_n = pos_inc;
				end else begin
					do_start = 1'b1;
				end
			end
			PH_PREFIX0: begin
				if (in_entry.xchar) begin
					eb_n  = HEX_BASE;
					ph_n  = PH_AFTERX;
					pos_n = pos_inc;
				end else begin
					ph_n = PH_DIGITS;
					if (dig_in) begin
						do_take = 1'b1;
					end else begin
						do_finish = 1'b1;
					end
				end
			end
			PH_AFTERX: begin
				if (dig_in) begin
					do_take = 1'b1;
					ph_n    = PH_DIGITS;
				end else begin
					emit     = 1'b1;
					emit_off = (pos_c != '0) ? pos_c - 1'b1 : '0;
					ph_n     = PH_IDLE;
				end
			end
			PH_DIGITS: begin
				if (dig_in) begin
					do_take = 1'b1;
				end else begin
					do_finish = 1'b1;
				end
			end
			default: begin
				ph_n = ph_c;
			end
		endcase

		if (do_start) begin
			if (start_pfx) begin
				eb_n  = (cfg_b == '0) ? OCT_BASE : HEX_BASE;
				ph_n  = PH_PREFIX0;
				pos_n = pos_inc;
			end else begin
				eb_n = start_eb;
				if (dig_in) begin
					do_take = 1'b1;
					ph_n    = PH_DIGITS;
				end else begin
					emit = 1'b1;
					ph_n = PH_IDLE;
				end
			end
		end

		if (do_take) begin
			acc_n = prod[VAL_W-1:0];
			wr_n  = wr_c || (prod[PROD_W-1:VAL_W] != '0);
			pos_n = pos_inc;
		end

		if (do_finish) begin
			emit     = 1'b1;
			emit_val = neg_c ? ('0 - acc_c) : acc_c;
			emit_off = pos_c;
			emit_ovf = wr_c;
			ph_n     = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			acc_q <= '0;
			eb_q  <= '0;
			neg_q <= 1'b0;
			pos_q <= '0;
			wr_q  <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			if (in_take) begin
				ph_q  <= ph_n;
				acc_q <= acc_n;
				eb_q  <= eb_n;
				neg_q <= neg_n;
				pos_q <= pos_n;
				wr_q  <= wr_n;
			end
			if (in_take && emit) begin
				ov_q <= 1'b1;
			end else if (out_pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && emit) begin
			val_q <= emit_val;
			off_q <= emit_off;
			ovf_q <= emit_ovf;
		end
	end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import aip_pkg::*;

	localparam int STRING_CAP    = 1024;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD     = 150;
	localparam int STUCK_LIMIT   = 3000;
	localparam int RANDOM_WORDS  = 800;
	localparam int CALM_WORDS    = 150;

	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_LEAD, SCAN_SIGNED, SCAN_ZERO, SCAN_HEX, SCAN_DIGITS
	} scan_phase_t;

	typedef struct {
		logic [VAL_W-1:0] num;
		logic [OFF_W-1:0] at;
		logic             ovf;
	} parsed_number_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [CHAR_W-1:0] char_in = '0;
	logic              new_string = 1'b0;
	logic              empty;
	logic              pop = 1'b0;
	logic [VAL_W-1:0]  value;
	logic [OFF_W-1:0]  stop_offset;
	logic              overflow;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	ascii_integer_parser #(.MAX_LEN(STRING_CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .char_in(char_in), .new_string(new_string),
		.empty(empty), .pop(pop), .value(value), .stop_offset(stop_offset),
		.overflow(overflow),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser shadow state
	logic [BASE_W-1:0] cfg_radix = DEF_BASE;
	logic              cfg_signed = 1'b1;
	scan_phase_t       scan = SCAN_IDLE;
	logic [VAL_W-1:0]  acc = '0;
	logic [BASE_W-1:0] digit_radix = '0;
	logic              minus = 1'b0;
	int unsigned       col = 0;
	logic              wrap_seen = 1'b0;

	parsed_number_t pending_numbers[$];
	int mismatches = 0;
	int words_sent = 0;
	int send_gap_odds = 4;
	int take_gap_odds = 4;
	int hold_req = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int stuck_cycles = 0;

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("mismatch: %s", what);
	endtask

	function automatic bit is_blank(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic int unsigned digit_value(input logic [CHAR_W-1:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return 32'(c - CH_ZERO);
		if (c >= CH_UA && c <= CH_UZ)
			return c - CH_UA + 10;
		if (c >= CH_LA && c <= CH_LZ)
			return c - CH_LA + 10;
		return 99;
	endfunction

	function automatic void bump_col();
		if (col < STRING_CAP)
			col++;
	endfunction

	function automatic bit take_digit(input logic [CHAR_W-1:0] c);
		logic [PROD_W-1:0] prod;
		int unsigned r;
		int unsigned d;
		r = 32'((digit_radix != 0) ? digit_radix : DEF_BASE);
		d = digit_value(c);
		if (d >= r)
			return 1'b0;
		prod = PROD_W'(acc) * PROD_W'(r) + PROD_W'(d);
		if (prod[PROD_W-1:VAL_W] != 0)
			wrap_seen = 1'b1;
		acc = prod[VAL_W-1:0];
		bump_col();
		return 1'b1;
	endfunction

	task automatic note_result(input logic [VAL_W-1:0] num, input int unsigned at,
			input logic ovf);
		pending_numbers.push_back('{num, at[OFF_W-1:0], ovf});
		scan = SCAN_IDLE;
	endtask

	task automatic close_number();
		note_result(minus ? VAL_W'(0) - acc : acc, col, wrap_seen);
	endtask

	task automatic begin_number(input logic [CHAR_W-1:0] c);
		int unsigned r;
		r = 32'((cfg_radix > MAX_BASE) ? MAX_BASE : cfg_radix);
		if ((r == 0 || r == HEX_BASE) && c == CH_ZERO) begin
			digit_radix = (r != 0) ? HEX_BASE : OCT_BASE;
			scan = SCAN_ZERO;
			bump_col();
		end else begin
			digit_radix = (r != 0) ? BASE_W'(r) : DEF_BASE;
			if (take_digit(c))
				scan = SCAN_DIGITS;
			else
				note_result('0, 0, 1'b0);
		end
	endtask

	task automatic parse_char(input logic [CHAR_W-1:0] c, input logic fresh);
		if (fresh) begin
			scan = SCAN_LEAD;
			acc = '0;
			digit_radix = '0;
			minus = 1'b0;
			col = 0;
			wrap_seen = 1'b0;
		end
		case (scan)
			SCAN_LEAD: begin
				if (is_blank(c))
					bump_col();
				else if (cfg_signed && (c == CH_MINUS || c == CH_PLUS)) begin
					minus = (c == CH_MINUS);
					scan = SCAN_SIGNED;
					bump_col();
				end else
					begin_number(c);
			end
			SCAN_SIGNED: begin
				if (is_blank(c))
					bump_col();
				else
					begin_number(c);
			end
			SCAN_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					digit_radix = HEX_BASE;
					scan = SCAN_HEX;
					bump_col();
				end else begin
					scan = SCAN_DIGITS;
					if (!take_digit(c))
						close_number();
				end
			end
			SCAN_HEX: begin
				if (take_digit(c))
					scan = SCAN_DIGITS;
				else
					note_result('0, (col != 0) ? col - 1 : 0, 1'b0);
			end
			SCAN_DIGITS: begin
				if (!take_digit(c))
					close_number();
			end
			default: ;
		endcase
	endtask

	task automatic send_word(input logic [CHAR_W-1:0] c, input logic fresh);
		if (send_gap_odds != 0 && $urandom_range(0, send_gap_odds) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		push <= 1'b1;
		char_in <= c;
		new_string <= fresh;
		@(posedge clk);
		while (full) @(posedge clk);
		parse_char(c, fresh);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], i == 0);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_numbers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_BASE)
			cfg_radix = data[BASE_W-1:0];
		else
			cfg_signed = data[0];
		@(posedge clk);
	endtask

	task automatic set_mode(input int radix, input bit sgn);
		wait_drained();
		write_reg(REG_BASE, {(APB_DW-BASE_W)'($urandom), BASE_W'(radix)});
		write_reg(REG_SIGNED, {(APB_DW-1)'($urandom), sgn});
	endtask

	function automatic logic [CHAR_W-1:0] pick_blank();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input int d);
		if (d < 10)
			return 8'(CH_ZERO + d);
		return 8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + d - 10);
	endfunction

	task automatic send_random_string();
		logic [CHAR_W-1:0] text[$];
		int radix;
		int ndig;
		bit zero_lead;
		bit x_lead;
		repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
		if ($urandom_range(0, 3) == 0) begin
			text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
			repeat ($urandom_range(0, 1)) text.push_back(pick_blank());
		end
		zero_lead = $urandom_range(0, 4) < 2;
		x_lead = zero_lead && $urandom_range(0, 1);
		if (zero_lead)
			text.push_back(CH_ZERO);
		if (x_lead)
			text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
		radix = 32'((cfg_radix > MAX_BASE) ? MAX_BASE : cfg_radix);
		if (radix == 0)
			radix = x_lead ? 16 : (zero_lead ? 8 : 10);
		ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 12);
		repeat (ndig) begin
			if ($urandom_range(0, 24) == 0)
				text.push_back(digit_char($urandom_range(0, 35)));
			else
				text.push_back(digit_char($urandom_range(0, radix - 1)));
		end
		// an unterminated string is dropped by the next one
		if ($urandom_range(0, 7) != 0)
			text.push_back($urandom_range(0, 2) == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
		foreach (text[i])
			send_word(text[i], i == 0);
		words_sent += text.size();
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(3, 12);
		repeat (n)
			send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
		words_sent += n;
	endtask

	task automatic check_number();
		parsed_number_t want;
		if (pending_numbers.size() == 0) begin
			flag_mismatch($sformatf("unexpected result value %h offset %0d", value,
				stop_offset));
			return;
		end
		want = pending_numbers.pop_front();
		if (value !== want.num)
			flag_mismatch($sformatf("value %h, want %h", value, want.num));
		if (stop_offset !== want.at)
			flag_mismatch($sformatf("stop_offset %0d, want %0d", stop_offset, want.at));
		if (overflow !== want.ovf)
			flag_mismatch($sformatf("overflow %b, want %b", overflow, want.ovf));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_number();
			if (hold_req != hold_taken) begin
				hold_taken = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (take_gap_odds != 0 && $urandom_range(0, take_gap_odds) == 0) begin
				hold_left = $urandom_range(0, 7);
				pop <= 1'b0;
			end else
				pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			stuck_cycles <= 0;
		else if (stuck_cycles == STUCK_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	task automatic test_power_on();
		// words before the first new_string are ignored
		send_word("7", 1'b0);
		send_word(8'hff, 1'b0);
		send_text("\t -  42");
		send_word(8'h00, 1'b0);
		send_text(" +");
		send_word("!", 1'b0);
		send_word("1", 1'b1);
		send_word("2", 1'b0);
		send_text("9");
		send_word(8'hff, 1'b0);
		send_text("-0");
		send_word(".", 1'b0);
	endtask

	task automatic test_radix_detect();
		set_mode(0, 1'b0);
		send_text("0x1f");
		send_word("Z", 1'b0);
		send_text("0X");
		send_word("g", 1'b0);
		send_text("017");
		send_word("9", 1'b0);
		send_text("+5");
		send_word(8'h00, 1'b0);
		send_text("42");
		send_word(8'h00, 1'b0);
	endtask

	task automatic test_odd_radix();
		set_mode(1, 1'b0);
		send_text("00");
		send_word("1", 1'b0);
		set_mode(63, 1'b1);
		send_text("-Zz");
		send_word(".", 1'b0);
		set_mode(MAX_BASE, 1'b1);
		send_text("zzzzzzZZZZZZZ");
		send_word(8'h00, 1'b0);
		set_mode(HEX_BASE, 1'b1);
		send_text("0xfF");
		send_word(8'hff, 1'b0);
		send_text("0x");
		send_word("x", 1'b0);
	endtask

	task automatic test_live_reconfig();
		set_mode(10, 1'b1);
		send_text("  -");
		set_mode(2, 1'b0);
		send_word("1", 1'b0);
		send_word("0", 1'b0);
		send_word("1", 1'b0);
		send_word(8'h00, 1'b0);
		send_text("  ");
		set_mode(2, 1'b1);
		send_word("-", 1'b0);
		send_word("1", 1'b0);
		send_word(8'h00, 1'b0);
	endtask

	task automatic test_long_string();
		set_mode(10, 1'b1);
		send_word(CH_SPACE, 1'b1);
		repeat (599) send_word(CH_SPACE, 1'b0);
		repeat (500) send_word("9", 1'b0);
		send_word(8'h00, 1'b0);
	endtask

	task automatic test_backpressure();
		set_mode(10, 1'b1);
		send_gap_odds = 0;
		hold_req++;
		repeat (20) begin
			send_text("7");
			send_word(8'h00, 1'b0);
		end
		send_gap_odds = 4;
	endtask

	task automatic test_drain_pause();
		repeat (3) begin
			repeat (4) send_random_string();
			push <= 1'b0;
			@(posedge clk);
			while (pending_numbers.size() != 0) @(posedge clk);
		end
	endtask

	task automatic test_random_strings();
		int goal;
		int pick;
		int odds[3] = '{0, 3, 8};
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			pick = $urandom_range(0, 7);
			case (pick)
				0: set_mode(0, $urandom_range(0, 1));
				1: set_mode(1, $urandom_range(0, 1));
				2: set_mode(2, $urandom_range(0, 1));
				3: set_mode(8, $urandom_range(0, 1));
				4: set_mode(10, $urandom_range(0, 1));
				5: set_mode(16, $urandom_range(0, 1));
				6: set_mode(36, $urandom_range(0, 1));
				default: set_mode($urandom_range(37, 63), $urandom_range(0, 1));
			endcase
			if (words_sent >= RANDOM_WORDS - CALM_WORDS) begin
				send_gap_odds = 0;
				take_gap_odds = 0;
			end else begin
				send_gap_odds = odds[$urandom_range(0, 2)];
				take_gap_odds = odds[$urandom_range(0, 2)];
			end
			goal = words_sent + $urandom_range(50, 100);
			while (words_sent < goal) begin
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					send_random_string();
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on();
		test_radix_detect();
		test_odd_radix();
		test_live_reconfig();
		test_long_string();
		test_backpressure();
		test_drain_pause();
		test_random_strings();
		wait_drained();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
